FILE: rtl/mnep_pkg.sv
// ----------------------------------------------------------------------------
// mnep_pkg
// Types and constants shared by the MIDI note event parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mnep_pkg;

	// Field widths of the received byte and of one event.
	localparam int BYTE_W    = 8;
	localparam int CHAN_W    = 5;
	localparam int NOTE_W    = 7;
	localparam int VEL_W     = 7;
	localparam int SIZE_W    = 7;
	localparam int COL_W     = 8;
	localparam int CNT_W     = 4;
	localparam int OCTAVE_W  = 4;

	// Per-note storage.
	localparam int NOTE_COUNT = 128;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_A     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_B     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_C     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_DIVISOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_VEL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_OCTAVE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET   = 3'd6;

	// Byte codes.
	localparam logic [BYTE_W-1:0] STATUS_SWALLOW = 8'hB0;
	localparam logic [2:0]        KIND_NOTE_OFF  = 3'd0;
	localparam logic [2:0]        KIND_NOTE_ON   = 3'd1;

	// Message byte positions.
	localparam logic [1:0] POS_IDLE     = 2'd0;
	localparam logic [1:0] POS_NOTE     = 2'd1;
	localparam logic [1:0] POS_VELOCITY = 2'd2;

	// Shape size floor and restoring divider length.
	localparam logic [SIZE_W-1:0] MIN_SIZE  = 7'd2;
	localparam int                DIV_STEPS = VEL_W;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOOKUP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic parse;
		logic div_start;
		logic div_step;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic msg_ready;
		logic msg_is_on;
		logic cnt_zero;
		logic div_last;
		logic out_free;
	} sts_t;

	// Semitone flag: pitch class 1, 3, 6, 8 or 10. The quotient by twelve is
	// taken as a multiply by 43 and a shift by 9, exact for 7-bit notes.
	function automatic logic is_semitone(input logic [NOTE_W-1:0] n);
		logic [12:0] prod;
		logic [3:0]  quo;
		logic [7:0]  pc;
		prod = 13'(n) * 13'd43;
		quo  = prod[12:9];
		pc   = 8'(n) - 8'(quo) * 8'd12;
		return pc inside {8'd1, 8'd3, 8'd6, 8'd8, 8'd10};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/mnep_ifs.sv
// ----------------------------------------------------------------------------
// mnep_ifs
// Valid/ready channels for received bytes and for note events.
// ----------------------------------------------------------------------------
`default_nettype none

interface mnep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mnep_out_if;
	logic       valid;
	logic       ready;
	logic       note_on;
	logic [4:0] channel;
	logic [6:0] note;
	logic [6:0] velocity;
	logic [6:0] shape_size;
	logic [7:0] column;
	logic       semitone;
	logic [3:0] repeat_count;

	modport source (output valid, output note_on, output channel, output note,
		output velocity, output shape_size, output column, output semitone,
		output repeat_count, input ready);
	modport sink   (input valid, input note_on, input channel, input note,
		input velocity, input shape_size, input column, input semitone,
		input repeat_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/midi_note_event_parser.sv
// ----------------------------------------------------------------------------
// midi_note_event_parser: frames MIDI note-on/off messages into note events.
// Events: a note-off event passes decode, lookup and finish, a note-on event also
// the 7-step divider, before it is valid; a stalled event holds the parser longer.
// Bytes: taken one at a time; a new byte is taken only once the last one is done.
// Reset: asynchronous, resets framing and config and clears all hold counts at once.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_event_parser #(
	parameter int MAX_HOLD = 15
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mnep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mnep_pkg::CFG_DATA_W-1:0]    cfg_data,
	mnep_in_if.sink                                 rx,
	mnep_out_if.source                              evt
);
	import mnep_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ready;

	assign rx.ready = ready;

	// Sequencer.
	mnep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	mnep_dp #(
		.MAX_HOLD (MAX_HOLD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.sts       (sts),
		.evt       (evt)
	);

endmodule

`default_nettype wire

FILE: rtl/mnep_ctrl.sv
// ----------------------------------------------------------------------------
// mnep_ctrl
// Sequencer for the note event parser: one received byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mnep_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rx_valid,
	output logic               rx_ready,
	input  wire mnep_pkg::sts_t sts,
	output mnep_pkg::cmd_t     cmd
);
	import mnep_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (rx_valid) state_next = ST_DECODE;
			end
			ST_DECODE: begin
				state_next = sts.msg_ready ? ST_LOOKUP : ST_IDLE;
			end
			ST_LOOKUP: begin
				if (sts.msg_is_on) begin
					state_next = ST_DIVIDE;
				end else if (sts.cnt_zero) begin
					state_next = ST_IDLE;
				end else begin
					state_next = ST_FINISH;
				end
			end
			ST_DIVIDE: begin
				if (sts.div_last) state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		rx_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				rx_ready    = 1'b1;
				cmd.capture = rx_valid;
			end
			ST_DECODE: begin
				cmd.parse = 1'b1;
			end
			ST_LOOKUP: begin
				cmd.div_start = sts.msg_is_on;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				rx_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/mnep_dp.sv
// ----------------------------------------------------------------------------
// mnep_dp
// Datapath: configuration, message framing, per-note memories, divider
// and the event output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mnep_dp #(
	parameter int MAX_HOLD = 15
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mnep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mnep_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [mnep_pkg::BYTE_W-1:0]        rx_byte,
	input  wire mnep_pkg::cmd_t                     cmd,
	output mnep_pkg::sts_t                          sts,
	mnep_out_if.source                              evt
);
	import mnep_pkg::*;

	localparam int               HoldLimitInt = (MAX_HOLD < 15) ? MAX_HOLD : 15;
	localparam logic [CNT_W-1:0] HoldLimit    = CNT_W'(HoldLimitInt);

	// Configuration registers.
	logic [CHAN_W-1:0]   listen_a_q, listen_b_q, listen_c_q;
	logic [VEL_W-1:0]    divisor_q, fixed_vel_q;
	logic [OCTAVE_W-1:0] base_octave_q;
	logic [COL_W-1:0]    col_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_a_q    <= '0;
			listen_b_q    <= '0;
			listen_c_q    <= '0;
			divisor_q     <= 7'd12;
			fixed_vel_q   <= '0;
			base_octave_q <= '0;
			col_offset_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LISTEN_A:    listen_a_q    <= cfg_data[CHAN_W-1:0];
				CFG_LISTEN_B:    listen_b_q    <= cfg_data[CHAN_W-1:0];
				CFG_LISTEN_C:    listen_c_q    <= cfg_data[CHAN_W-1:0];
				CFG_VEL_DIVISOR: divisor_q     <= cfg_data[VEL_W-1:0];
				CFG_FIXED_VEL:   fixed_vel_q   <= cfg_data[VEL_W-1:0];
				CFG_BASE_OCTAVE: base_octave_q <= cfg_data[OCTAVE_W-1:0];
				CFG_COL_OFFSET:  col_offset_q  <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// Captured byte.
	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) byte_q <= rx_byte;
	end

	// Framing state.
	logic [1:0]        pos_q;
	logic [3:0]        cur_chan_q;
	logic              cur_is_on_q;
	logic [NOTE_W-1:0] cur_note_q;
	logic              swallow_q;
	logic [VEL_W-1:0]  vel_q;

	logic [2:0]        kind;
	logic [CHAN_W-1:0] chan_num;
	logic              chan_ok;
	logic              is_third;

	assign kind     = byte_q[6:4];
	assign chan_num = {1'b0, cur_chan_q} + 5'd1;
	assign chan_ok  = (listen_a_q == '0) || (chan_num == listen_a_q) ||
		(chan_num == listen_b_q) || (chan_num == listen_c_q);
	assign is_third = (byte_q <= STATUS_SWALLOW) && !byte_q[7] &&
		(pos_q != POS_IDLE) && (pos_q != POS_NOTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_IDLE;
			cur_chan_q  <= '0;
			cur_is_on_q <= 1'b0;
			cur_note_q  <= '0;
			swallow_q   <= 1'b0;
		end else if (cmd.parse && (byte_q <= STATUS_SWALLOW)) begin
			if (byte_q[7]) begin
				// Status byte: note messages restart framing, others reset it.
				if (byte_q == STATUS_SWALLOW) swallow_q <= 1'b1;
				if ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON)) begin
					cur_chan_q  <= byte_q[3:0];
					cur_is_on_q <= (kind == KIND_NOTE_ON);
					pos_q       <= POS_NOTE;
				end else begin
					pos_q <= POS_IDLE;
				end
			end else if (pos_q == POS_NOTE) begin
				cur_note_q <= byte_q[NOTE_W-1:0];
				pos_q      <= POS_VELOCITY;
			end else if (pos_q != POS_IDLE) begin
				pos_q <= POS_IDLE;
				if (swallow_q) swallow_q <= 1'b0;
			end
		end
	end

	// Velocity of a note-on, fixed or received.
	always_ff @(posedge clk) begin
		if (cmd.parse) begin
			vel_q <= (fixed_vel_q != '0) ? fixed_vel_q : byte_q[VEL_W-1:0];
		end
	end

	// Per-note memories, read while the byte is decoded. The valid bits
	// stand for the cleared reset state of the hold counts.
	logic [CNT_W-1:0]      hold_mem [NOTE_COUNT];
	logic [VEL_W-1:0]      vel_mem  [NOTE_COUNT];
	logic [NOTE_COUNT-1:0] hold_vld_q;
	logic [CNT_W-1:0]      hold_rd_q;
	logic [VEL_W-1:0]      vel_rd_q;
	logic                  vld_rd_q;
	logic [CNT_W-1:0]      cnt;
	logic [CNT_W-1:0]      cnt_next;

	assign cnt      = vld_rd_q ? hold_rd_q : '0;
	assign cnt_next = (cnt < HoldLimit) ? cnt + 4'd1 : cnt;

	always_ff @(posedge clk) begin
		if (cmd.parse) begin
			hold_rd_q <= hold_mem[cur_note_q];
			vel_rd_q  <= vel_mem[cur_note_q];
			vld_rd_q  <= hold_vld_q[cur_note_q];
		end
		if (cmd.commit && cur_is_on_q) begin
			hold_mem[cur_note_q] <= cnt_next;
			vel_mem[cur_note_q]  <= vel_q;
		end
	end

	// A note-off releases the note by clearing its valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= '0;
		end else if (cmd.commit) begin
			hold_vld_q[cur_note_q] <= cur_is_on_q;
		end
	end

	// Restoring divider, one quotient bit a cycle. A zero divisor yields
	// all ones, which is the saturated size.
	logic [VEL_W-1:0]         div_rem_q;
	logic [VEL_W-1:0]         div_quo_q;
	logic [2:0]               div_cnt_q;
	logic [VEL_W:0]           rem_sh;
	logic                     rem_ge;

	assign rem_sh = {div_rem_q, div_quo_q[VEL_W-1]};
	assign rem_ge = rem_sh >= {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= vel_q;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_rem_q <= rem_ge ? VEL_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[VEL_W-1:0];
			div_quo_q <= {div_quo_q[VEL_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + 3'd1;
		end
	end

	// Event fields.
	logic [SIZE_W-1:0] size_on;
	logic [SIZE_W-1:0] last_size_q;
	logic [COL_W-1:0]  octave_span;
	logic [COL_W-1:0]  column;

	assign size_on     = (div_quo_q < MIN_SIZE) ? MIN_SIZE : div_quo_q;
	assign octave_span = COL_W'({base_octave_q, 3'b000}) + COL_W'({base_octave_q, 2'b00});
	assign column      = COL_W'({1'b0, cur_note_q}) - octave_span + col_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_size_q <= '0;
		end else if (cmd.commit && cur_is_on_q) begin
			last_size_q <= size_on;
		end
	end

	// Output register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			evt.note_on      <= cur_is_on_q;
			evt.channel      <= chan_num;
			evt.note         <= cur_note_q;
			evt.velocity     <= cur_is_on_q ? vel_q : vel_rd_q;
			evt.shape_size   <= cur_is_on_q ? size_on : last_size_q;
			evt.column       <= column;
			evt.semitone     <= is_semitone(cur_note_q);
			evt.repeat_count <= cur_is_on_q ? 4'd1 : cnt;
		end
	end

	assign evt.valid = out_valid_q;

	// Status.
	assign sts.msg_ready = (byte_q <= STATUS_SWALLOW) && is_third && !swallow_q && chan_ok;
	assign sts.msg_is_on = cur_is_on_q;
	assign sts.cnt_zero  = (cnt == '0);
	assign sts.div_last  = (div_cnt_q == 3'(DIV_STEPS - 1));
	assign sts.out_free  = !out_valid_q || evt.ready;

endmodule

`default_nettype wire
